// ----- rtl/wsd_pkg.sv -----
// shared types and constants for the websocket frame deframer
package wsd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 64;
    localparam int unsigned KEY_W  = 32;

    // error codes
    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_PROTO  = 2'd1,
        ERR_OPCODE = 2'd2,
        ERR_BIG    = 2'd3
    } wsd_err_t;

    // configuration register indexes
    localparam logic CFG_EXPECT_MASKED = 1'b0;
    localparam logic CFG_MAX_LENGTH    = 1'b1;

    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = LEN_W'(65536);

    // one result of the parser
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_payload;
        logic              header_done;
        logic              frame_done;
        logic              fin_flag;
        logic [3:0]        frame_opcode;
        logic [LEN_W-1:0]  payload_length;
        wsd_err_t          error_status;
    } wsd_result_t;

endpackage

// ----- rtl/wsd_parser.sv -----
// frame header walker, length checks and payload unmasking, one byte per cycle while step is high
module wsd_parser
    import wsd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  logic [BYTE_W-1:0]  in_byte,
    input  logic               expect_masked,
    input  logic [LEN_W-1:0]   max_length,
    output wsd_result_t        result
);

    typedef enum logic [2:0] {
        ST_FLAGS   = 3'd0,
        ST_LEN     = 3'd1,
        ST_EXTLEN  = 3'd2,
        ST_KEY     = 3'd3,
        ST_PAYLOAD = 3'd4
    } stage_t;

    localparam logic [6:0] CODE_EXT16   = 7'd126;
    localparam logic [6:0] CODE_EXT64   = 7'd127;
    localparam logic [6:0] CODE_CTL_MAX = 7'd125;

    stage_t            stage_reg, stage_next;
    logic [LEN_W-1:0]  bytes_left_reg, bytes_left_next;
    logic [LEN_W-1:0]  accum_reg, accum_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [1:0]        key_idx_reg, key_idx_next;
    logic              fin_reg, fin_next;
    logic [3:0]        opcode_reg, opcode_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    wsd_err_t          err_reg, err_next;

    logic              do_finish;
    logic [LEN_W-1:0]  fin_len;
    logic [LEN_W-1:0]  accum_shift;
    logic [6:0]        code;
    logic [BYTE_W-1:0] key_byte;
    logic [BYTE_W-1:0] data;
    logic              payload, hdr, fend;

    assign code        = in_byte[6:0];
    assign accum_shift = {accum_reg[LEN_W-BYTE_W-1:0], in_byte};

    always_comb begin
        case (key_idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb begin
        stage_next      = stage_reg;
        bytes_left_next = bytes_left_reg;
        accum_next      = accum_reg;
        key_next        = key_reg;
        key_idx_next    = key_idx_reg;
        fin_next        = fin_reg;
        opcode_next     = opcode_reg;
        length_next     = length_reg;
        err_next        = err_reg;
        do_finish       = 1'b0;
        fin_len         = '0;
        data            = '0;
        payload         = 1'b0;
        hdr             = 1'b0;
        fend            = 1'b0;

        if (err_reg == ERR_NONE) begin
            unique case (stage_reg)
                ST_LEN: begin
                    if (in_byte[7] != expect_masked) begin
                        err_next = ERR_PROTO;
                    end else if (opcode_reg[3] && code > CODE_CTL_MAX) begin
                        err_next = ERR_BIG;
                    end else if (code == CODE_EXT64 || code == CODE_EXT16) begin
                        bytes_left_next = (code == CODE_EXT64) ? LEN_W'(8) : LEN_W'(2);
                        accum_next      = '0;
                        stage_next      = ST_EXTLEN;
                    end else begin
                        length_next = LEN_W'(code);
                        fin_len     = LEN_W'(code);
                        do_finish   = 1'b1;
                    end
                end
                ST_EXTLEN: begin
                    accum_next      = accum_shift;
                    bytes_left_next = bytes_left_reg - LEN_W'(1);
                    if (bytes_left_reg == LEN_W'(1)) begin
                        length_next = accum_shift;
                        accum_next  = '0;
                        fin_len     = accum_shift;
                        do_finish   = 1'b1;
                    end
                end
                ST_KEY: begin
                    key_next = {key_reg[KEY_W-BYTE_W-1:0], in_byte};
                    if (key_idx_reg == 2'd3) begin
                        key_idx_next    = 2'd0;
                        bytes_left_next = length_reg;
                        hdr             = 1'b1;
                        if (length_reg == '0) begin
                            stage_next = ST_FLAGS;
                            fend       = 1'b1;
                        end else begin
                            stage_next = ST_PAYLOAD;
                        end
                    end else begin
                        key_idx_next = key_idx_reg + 2'd1;
                    end
                end
                ST_PAYLOAD: begin
                    data            = in_byte ^ key_byte;
                    payload         = 1'b1;
                    key_idx_next    = key_idx_reg + 2'd1;
                    bytes_left_next = bytes_left_reg - LEN_W'(1);
                    if (bytes_left_reg == LEN_W'(1)) begin
                        stage_next = ST_FLAGS;
                        fend       = 1'b1;
                    end
                end
                default: begin
                    // flag byte, also covers the unused stage codes
                    fin_next        = in_byte[7];
                    opcode_next     = in_byte[3:0];
                    length_next     = '0;
                    key_next        = '0;
                    key_idx_next    = 2'd0;
                    bytes_left_next = '0;
                    accum_next      = '0;
                    stage_next      = ST_FLAGS;
                    if (in_byte[6:4] != 3'b000) begin
                        err_next = ERR_PROTO;
                    end else if (in_byte[3:0] >= 4'd3 && in_byte[3:0] <= 4'd7) begin
                        err_next = ERR_OPCODE;
                    end else if (in_byte[3:0] >= 4'd11) begin
                        err_next = ERR_PROTO;
                    end else if (!in_byte[7] && in_byte[3]) begin
                        err_next = ERR_PROTO;
                    end else begin
                        stage_next = ST_LEN;
                    end
                end
            endcase

            // header complete: length limit, then key or payload
            if (do_finish) begin
                if (fin_len > max_length) begin
                    err_next = ERR_BIG;
                end else if (expect_masked) begin
                    stage_next   = ST_KEY;
                    key_idx_next = 2'd0;
                    key_next     = '0;
                end else begin
                    bytes_left_next = fin_len;
                    hdr             = 1'b1;
                    if (fin_len == '0) begin
                        stage_next = ST_FLAGS;
                        fend       = 1'b1;
                    end else begin
                        stage_next = ST_PAYLOAD;
                    end
                end
            end
        end
    end

    always_comb begin
        result.out_byte       = data;
        result.is_payload     = payload;
        result.header_done    = hdr;
        result.frame_done     = fend;
        result.fin_flag       = fin_next;
        result.frame_opcode   = opcode_next;
        result.payload_length = length_next;
        result.error_status   = err_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg      <= ST_FLAGS;
            bytes_left_reg <= '0;
            accum_reg      <= '0;
            key_reg        <= '0;
            key_idx_reg    <= 2'd0;
            fin_reg        <= 1'b0;
            opcode_reg     <= '0;
            length_reg     <= '0;
            err_reg        <= ERR_NONE;
        end else if (step) begin
            stage_reg      <= stage_next;
            bytes_left_reg <= bytes_left_next;
            accum_reg      <= accum_next;
            key_reg        <= key_next;
            key_idx_reg    <= key_idx_next;
            fin_reg        <= fin_next;
            opcode_reg     <= opcode_next;
            length_reg     <= length_next;
            err_reg        <= err_next;
        end
    end

endmodule

// ----- rtl/websocket_frame_deframer.sv -----
// websocket frame deframer top level: configuration registers and result register
// Takes one received byte per request and gives one result per byte, one per clock
// cycle sustained while m_ready stays high; a result appears on the m_ side in the
// cycle after its byte is accepted and is held in an output register, so a new byte
// is taken while the previous result is being taken. The cycle time is set by the
// state update, whose longest path is the 64-bit extended length shift followed by
// the 64-bit compare against max_length. Configuration writes are taken at once.
module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [LEN_W-1:0]   cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [BYTE_W-1:0]  s_in_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [BYTE_W-1:0]  m_out_byte,
    output logic               m_is_payload,
    output logic               m_header_done,
    output logic               m_frame_done,
    output logic               m_fin_flag,
    output logic [3:0]         m_frame_opcode,
    output logic [LEN_W-1:0]   m_payload_length,
    output logic [1:0]         m_error_status
);

    logic             expect_masked_reg;
    logic [LEN_W-1:0] max_length_reg;
    logic             m_valid_reg;
    wsd_result_t      res_reg;
    wsd_result_t      res_comb;
    logic             accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    wsd_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (accept),
        .in_byte       (s_in_byte),
        .expect_masked (expect_masked_reg),
        .max_length    (max_length_reg),
        .result        (res_comb)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_masked_reg <= 1'b1;
            max_length_reg    <= MAX_LENGTH_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_EXPECT_MASKED: expect_masked_reg <= cfg_wr_data[0];
                CFG_MAX_LENGTH:    max_length_reg    <= cfg_wr_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_comb;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_byte       = res_reg.out_byte;
    assign m_is_payload     = res_reg.is_payload;
    assign m_header_done    = res_reg.header_done;
    assign m_frame_done     = res_reg.frame_done;
    assign m_fin_flag       = res_reg.fin_flag;
    assign m_frame_opcode   = res_reg.frame_opcode;
    assign m_payload_length = res_reg.payload_length;
    assign m_error_status   = res_reg.error_status;

endmodule

// ----- sim/websocket_frame_deframer_test.sv -----
// self-checking testbench for the websocket frame deframer
module websocket_frame_deframer_test;
    import wsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    localparam logic [6:0] LEN_CODE_16  = 7'd126;
    localparam logic [6:0] LEN_CODE_64  = 7'd127;
    localparam logic [6:0] CTRL_LEN_MAX = 7'd125;

    localparam int ITEM_TARGET = 700;

    typedef enum logic [2:0] {
        AWAIT_FLAGS, AWAIT_LEN, EXT_LEN, KEY_BYTES, IN_PAYLOAD
    } parse_stage_t;

    typedef enum int {FORM_SHORT, FORM_16, FORM_64} len_form_t;

    typedef enum int {
        BAD_RSV, BAD_DATA_OP, BAD_CTRL_OP, FRAG_CTRL, BAD_MASK, CTRL_TOO_LONG, OVER_LIMIT
    } fault_t;

    typedef logic [7:0] octet_q_t[$];

    class deframe_scoreboard;
        bit           expect_masked;
        logic [63:0]  max_length;
        parse_stage_t stage;
        logic [63:0]  bytes_left;
        logic [63:0]  length_accum;
        logic [63:0]  cur_length;
        logic [31:0]  mask_key;
        logic [1:0]   key_index;
        logic         cur_fin;
        logic [3:0]   cur_opcode;
        wsd_err_t     sticky;
        wsd_result_t  expected[$];
        int           errors;

        function new();
            expect_masked = 1'b1;
            max_length    = MAX_LENGTH_RESET;
            stage         = AWAIT_FLAGS;
            bytes_left    = '0;
            length_accum  = '0;
            cur_length    = '0;
            mask_key      = '0;
            key_index     = '0;
            cur_fin       = 1'b0;
            cur_opcode    = OP_CONT;
            sticky        = ERR_NONE;
            errors        = 0;
        endfunction

        function void set_reg(logic idx, logic [63:0] value);
            if (idx == CFG_EXPECT_MASKED) begin
                expect_masked = value[0];
            end else begin
                max_length = value;
            end
        endfunction

        function int pending();
            return expected.size();
        endfunction

        // length fully decoded: limit check, then key or payload
        function void finish_header(inout wsd_result_t r);
            if (cur_length > max_length) begin
                sticky = ERR_BIG;
                return;
            end
            if (expect_masked) begin
                stage     = KEY_BYTES;
                key_index = '0;
                mask_key  = '0;
                return;
            end
            bytes_left    = cur_length;
            r.header_done = 1'b1;
            if (bytes_left == 0) begin
                stage        = AWAIT_FLAGS;
                r.frame_done = 1'b1;
            end else begin
                stage = IN_PAYLOAD;
            end
        endfunction

        function void note_byte(logic [7:0] b);
            wsd_result_t r;
            logic [6:0]  code;
            r    = '0;
            code = b[6:0];
            if (sticky == ERR_NONE) begin
                case (stage)
                    AWAIT_LEN: begin
                        if (b[7] != expect_masked) begin
                            sticky = ERR_PROTO;
                        end else if (cur_opcode >= OP_CLOSE && code > CTRL_LEN_MAX) begin
                            sticky = ERR_BIG;
                        end else if (code == LEN_CODE_16 || code == LEN_CODE_64) begin
                            bytes_left   = (code == LEN_CODE_64) ? 64'd8 : 64'd2;
                            length_accum = '0;
                            stage        = EXT_LEN;
                        end else begin
                            cur_length = 64'(code);
                            finish_header(r);
                        end
                    end
                    EXT_LEN: begin
                        length_accum = {length_accum[55:0], b};
                        bytes_left--;
                        if (bytes_left == 0) begin
                            cur_length   = length_accum;
                            length_accum = '0;
                            finish_header(r);
                        end
                    end
                    KEY_BYTES: begin
                        mask_key = {mask_key[23:0], b};
                        if (key_index == 2'd3) begin
                            key_index     = '0;
                            bytes_left    = cur_length;
                            r.header_done = 1'b1;
                            if (bytes_left == 0) begin
                                stage        = AWAIT_FLAGS;
                                r.frame_done = 1'b1;
                            end else begin
                                stage = IN_PAYLOAD;
                            end
                        end else begin
                            key_index++;
                        end
                    end
                    IN_PAYLOAD: begin
                        // first key byte sits in the top of the key word
                        r.out_byte   = b ^ mask_key[8*(3-key_index) +: 8];
                        r.is_payload = 1'b1;
                        key_index++;
                        bytes_left--;
                        if (bytes_left == 0) begin
                            stage        = AWAIT_FLAGS;
                            r.frame_done = 1'b1;
                        end
                    end
                    default: begin
                        cur_fin      = b[7];
                        cur_opcode   = b[3:0];
                        cur_length   = '0;
                        mask_key     = '0;
                        key_index    = '0;
                        bytes_left   = '0;
                        length_accum = '0;
                        if (b[6:4] != 3'b000) begin
                            sticky = ERR_PROTO;
                        end else if (cur_opcode > OP_BINARY && cur_opcode < OP_CLOSE) begin
                            sticky = ERR_OPCODE;
                        end else if (cur_opcode > OP_PONG) begin
                            sticky = ERR_PROTO;
                        end else if (!cur_fin && cur_opcode >= OP_CLOSE) begin
                            sticky = ERR_PROTO;
                        end else begin
                            stage = AWAIT_LEN;
                        end
                    end
                endcase
            end
            r.fin_flag       = cur_fin;
            r.frame_opcode   = cur_opcode;
            r.payload_length = cur_length;
            r.error_status   = sticky;
            expected.insert(expected.size(), r);
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            end
        endfunction

        function void check_result(wsd_result_t got);
            wsd_result_t want;
            if (expected.size() == 0) begin
                errors++;
                $display("%0t: result with no byte behind it, expected none, actual %h",
                         $time, got);
                return;
            end
            want = expected.pop_front();
            compare_field("out_byte", 64'(want.out_byte), 64'(got.out_byte));
            compare_field("is_payload", 64'(want.is_payload), 64'(got.is_payload));
            compare_field("header_done", 64'(want.header_done), 64'(got.header_done));
            compare_field("frame_done", 64'(want.frame_done), 64'(got.frame_done));
            compare_field("fin_flag", 64'(want.fin_flag), 64'(got.fin_flag));
            compare_field("frame_opcode", 64'(want.frame_opcode), 64'(got.frame_opcode));
            compare_field("payload_length", want.payload_length, got.payload_length);
            compare_field("error_status", 64'(want.error_status), 64'(got.error_status));
        endfunction
    endclass

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic              cfg_index   = CFG_EXPECT_MASKED;
    logic [LEN_W-1:0]  cfg_wr_data = '0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [BYTE_W-1:0] s_in_byte   = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic [BYTE_W-1:0] m_out_byte;
    logic              m_is_payload;
    logic              m_header_done;
    logic              m_frame_done;
    logic              m_fin_flag;
    logic [3:0]        m_frame_opcode;
    logic [LEN_W-1:0]  m_payload_length;
    logic [1:0]        m_error_status;

    deframe_scoreboard sb = new();
    bit steady = 1'b0;  // both sides run without gaps for this frame
    int sent   = 0;

    websocket_frame_deframer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_in_byte        (s_in_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_is_payload     (m_is_payload),
        .m_header_done    (m_header_done),
        .m_frame_done     (m_frame_done),
        .m_fin_flag       (m_fin_flag),
        .m_frame_opcode   (m_frame_opcode),
        .m_payload_length (m_payload_length),
        .m_error_status   (m_error_status)
    );

    always #5 aclk = ~aclk;

    function automatic logic [3:0] pick_opcode(bit control);
        case ($urandom_range(0, 2))
            0: return control ? OP_CLOSE : OP_CONT;
            1: return control ? OP_PING : OP_TEXT;
            default: return control ? OP_PONG : OP_BINARY;
        endcase
    endfunction

    function automatic logic [63:0] pick_limit();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 64'($urandom_range(1, 40));
            2: return 64'(CTRL_LEN_MAX);
            3: return 64'd126;
            4: return 64'hFFFF;
            5: return MAX_LENGTH_RESET;
            6: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // flag byte, length byte(s) and key when masked
    function automatic octet_q_t header_bytes(input bit fin, input logic [3:0] op,
            input logic [63:0] len, input bit masked, input len_form_t form);
        octet_q_t    q;
        logic [31:0] key;
        q.insert(q.size(), {fin, 3'b000, op});
        case (form)
            FORM_16: begin
                q.insert(q.size(), {masked, LEN_CODE_16});
                q.insert(q.size(), len[15:8]);
                q.insert(q.size(), len[7:0]);
            end
            FORM_64: begin
                q.insert(q.size(), {masked, LEN_CODE_64});
                for (int i = 7; i >= 0; i--) q.insert(q.size(), len[8*i +: 8]);
            end
            default: q.insert(q.size(), {masked, len[6:0]});
        endcase
        if (masked) begin
            key = $urandom;
            for (int i = 3; i >= 0; i--) q.insert(q.size(), key[8*i +: 8]);
        end
        return q;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(b);
        sent++;
    endtask

    task automatic send_octets(input octet_q_t q, input int first, input int last);
        for (int i = first; i < last; i++) send_byte(q[i]);
    endtask

    task automatic send_frame(input bit fin, input logic [3:0] op, input logic [63:0] len,
            input len_form_t form);
        octet_q_t q;
        q = header_bytes(fin, op, len, sb.expect_masked, form);
        repeat (int'(len)) q.insert(q.size(), 8'($urandom));
        send_octets(q, 0, q.size());
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [63:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        sb.set_reg(idx, value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_random_frame();
        bit          control;
        bit          fin;
        logic [3:0]  op;
        logic [63:0] cap;
        logic [63:0] len;
        len_form_t   form;
        steady  = ($urandom_range(0, 4) == 0);
        control = ($urandom_range(0, 3) == 0);
        cap     = (sb.max_length > 64'd300) ? 64'd300 : sb.max_length;
        if (control && cap > CTRL_LEN_MAX) cap = 64'(CTRL_LEN_MAX);
        op  = pick_opcode(control);
        fin = control ? 1'b1 : 1'($urandom_range(0, 1));
        case ($urandom_range(0, 15))
            0: len = 64'($urandom_range(0, int'(cap)));
            1: len = cap;
            default: len = 64'($urandom_range(0, (cap < 20) ? int'(cap) : 20));
        endcase
        if (control || (len <= CTRL_LEN_MAX && $urandom_range(0, 3) != 0)) begin
            form = FORM_SHORT;
        end else if (len <= 64'hFFFF && $urandom_range(0, 1) == 1) begin
            form = FORM_16;
        end else begin
            form = FORM_64;
        end
        send_frame(fin, op, len, form);
    endtask

    // one protocol violation, then bytes that must all be ignored
    task automatic send_broken_frame();
        fault_t      fault;
        octet_q_t    q;
        logic [63:0] lim;
        logic [63:0] len;
        steady = 1'b0;
        fault  = fault_t'($urandom_range(0, 6));
        case (fault)
            BAD_RSV:
                q.insert(q.size(),
                         {1'($urandom), 3'($urandom_range(1, 7)), pick_opcode(1'b0)});
            BAD_DATA_OP:
                q.insert(q.size(), {1'($urandom), 3'b000, 4'($urandom_range(3, 7))});
            BAD_CTRL_OP:
                q.insert(q.size(), {1'($urandom), 3'b000, 4'($urandom_range(11, 15))});
            FRAG_CTRL:
                q.insert(q.size(), {1'b0, 3'b000, pick_opcode(1'b1)});
            BAD_MASK: begin
                q = header_bytes(1'b1, OP_TEXT, 64'd5, sb.expect_masked, FORM_SHORT);
                q[1][7] = ~sb.expect_masked;
            end
            CTRL_TOO_LONG:
                q = header_bytes(1'b1, pick_opcode(1'b1), 64'd200, sb.expect_masked,
                                 ($urandom_range(0, 1) == 1) ? FORM_16 : FORM_64);
            default: begin
                lim = 64'($urandom_range(0, 1000));
                write_reg(CFG_MAX_LENGTH, lim);
                if ($urandom_range(0, 2) == 0) begin
                    q = header_bytes(1'b1, OP_BINARY, '1, sb.expect_masked, FORM_64);
                end else begin
                    len = lim + 1 + 64'($urandom_range(0, 100));
                    q = header_bytes(1'b1, OP_BINARY, len, sb.expect_masked,
                                     (len <= CTRL_LEN_MAX) ? FORM_SHORT : FORM_16);
                end
            end
        endcase
        repeat ($urandom_range(20, 40)) q.insert(q.size(), 8'($urandom));
        send_octets(q, 0, q.size());
    endtask

    initial begin : result_sink
        int          hold;
        wsd_result_t got;
        hold = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got.out_byte       = m_out_byte;
                got.is_payload     = m_is_payload;
                got.header_done    = m_header_done;
                got.frame_done     = m_frame_done;
                got.fin_flag       = m_fin_flag;
                got.frame_opcode   = m_frame_opcode;
                got.payload_length = m_payload_length;
                got.error_status   = wsd_err_t'(m_error_status);
                sb.check_result(got);
                hold = steady ? 0 : $urandom_range(0, 5);
            end
            if (hold != 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        octet_q_t split;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // masked frames under the reset settings
        send_frame(1'b1, OP_TEXT, 64'd0, FORM_SHORT);
        send_frame(1'b0, OP_BINARY, 64'd4, FORM_16);
        send_frame(1'b1, OP_PING, 64'd2, FORM_SHORT);

        // masking turned off part way through a payload
        split = header_bytes(1'b1, OP_CONT, 64'd6, 1'b1, FORM_SHORT);
        repeat (6) split.insert(split.size(), 8'($urandom));
        send_octets(split, 0, 8);
        write_reg(CFG_EXPECT_MASKED, 64'd0);
        send_octets(split, 8, split.size());

        send_frame(1'b1, OP_CLOSE, 64'd1, FORM_SHORT);
        send_frame(1'b1, OP_PONG, 64'd0, FORM_SHORT);
        write_reg(CFG_MAX_LENGTH, '0);
        send_frame(1'b1, OP_TEXT, 64'd0, FORM_64);
        write_reg(CFG_MAX_LENGTH, '1);
        send_frame(1'b0, OP_TEXT, 64'd3, FORM_64);
        send_frame(1'b1, OP_CONT, 64'd2, FORM_SHORT);

        while (sent < ITEM_TARGET) begin
            write_reg(CFG_EXPECT_MASKED, 64'($urandom_range(0, 1)));
            write_reg(CFG_MAX_LENGTH, pick_limit());
            repeat ($urandom_range(5, 15)) begin
                if (sent < ITEM_TARGET) send_random_frame();
            end
        end

        // any error sticks until reset, so the violation comes last
        send_broken_frame();

        wait_idle();
        repeat (4) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- websocket_frame_deframer.f -----
rtl/wsd_pkg.sv
rtl/wsd_parser.sv
rtl/websocket_frame_deframer.sv
sim/websocket_frame_deframer_test.sv
